FILE: sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the target position smoother
// Event codes, register map, reset values and field widths.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Default filter geometry: integer bits and fraction bits of each accumulator
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed widths of the stream fields
  localparam int FUNC_W  = 3;
  localparam int FIELD_W = 16;
  localparam int TIME_W  = 32;

  // Configuration port
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ALPHA_W = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 17'd19661;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd100;

  // Register index, taken from byte address bit 2
  typedef enum logic {
    REG_ALPHA   = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  // Event selector
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FRAME     = 3'd0,
    FUNC_TICK      = 3'd1,
    FUNC_INJECT    = 3'd2,
    FUNC_SET_READY = 3'd3,
    FUNC_FETCH     = 3'd4
  } func_t;

endpackage

FILE: sv/tps_event_if.sv
// ----------------------------------------------------------------------------
// tps_event_if: event request channel
// Valid/ready channel carrying one tracker event per request.
// ----------------------------------------------------------------------------
interface tps_event_if;
  logic                         valid;
  logic                         ready;
  logic [tps_pkg::FUNC_W-1:0]   func;
  logic [tps_pkg::FIELD_W-1:0]  x_coord;
  logic [tps_pkg::FIELD_W-1:0]  y_coord;
  logic [tps_pkg::FIELD_W-1:0]  frame_seq;
  logic [tps_pkg::TIME_W-1:0]   time_stamp;
  logic                         ready_flag;

  modport source (
    output valid, func, x_coord, y_coord, frame_seq, time_stamp, ready_flag,
    input  ready
  );
  modport sink (
    input  valid, func, x_coord, y_coord, frame_seq, time_stamp, ready_flag,
    output ready
  );
endinterface

FILE: sv/tps_status_if.sv
// ----------------------------------------------------------------------------
// tps_status_if: status result channel
// Valid/ready channel carrying the tracker state after each event.
// ----------------------------------------------------------------------------
interface tps_status_if;
  logic                         valid;
  logic                         ready;
  logic                         target_valid;
  logic                         target_fresh;
  logic [tps_pkg::FIELD_W-1:0]  smooth_x;
  logic [tps_pkg::FIELD_W-1:0]  smooth_y;
  logic [tps_pkg::FIELD_W-1:0]  latest_x;
  logic [tps_pkg::FIELD_W-1:0]  latest_y;
  logic [tps_pkg::FIELD_W-1:0]  latest_seq;
  logic                         fetch_ok;

  modport source (
    output valid, target_valid, target_fresh, smooth_x, smooth_y,
           latest_x, latest_y, latest_seq, fetch_ok,
    input  ready
  );
  modport sink (
    input  valid, target_valid, target_fresh, smooth_x, smooth_y,
           latest_x, latest_y, latest_seq, fetch_ok,
    output ready
  );
endinterface

FILE: sv/target_position_smoother_top.sv
// ----------------------------------------------------------------------------
// target_position_smoother_top: 2-D target tracker with EMA smoothing
// Frame, tick, inject, set-ready and fetch events with one status per event.
// ----------------------------------------------------------------------------
// Takes one event request per clock while the status side is not stalled,
// and returns one status request per event, in order: the event is
// captured in an input register, then the filter update, the timeout check
// and the flag logic run in one pass into the tracker state and the status
// register. That pass holds one multiplier per axis (error magnitude times
// alpha), which sets the clock-to-clock path. The status shows the state
// after its event; fetch_ok is high only for a fetch that found a valid
// target. Write smooth_alpha (byte address 0, Q1.16, values above 1.0 act
// as 1.0) and timeout_ticks (byte address 4) only while no event is in
// flight.
// ----------------------------------------------------------------------------
module target_position_smoother_top #(
  parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tps_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tps_event_if.sink                   events,
  tps_status_if.source                status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tps_pkg::ADDR_W-1:0]  paddr,
  input  logic [tps_pkg::DATA_W-1:0]  pwdata,
  output logic [tps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int FW    = tps_pkg::FIELD_W;
  localparam int TW    = tps_pkg::TIME_W;
  localparam int AW    = tps_pkg::ALPHA_W;
  // Accumulator width, and error magnitude width padded so that the
  // multiply keeps at least one bit above the 16 alpha fraction bits
  localparam int ACC_W = COORD_WIDTH + FRAC_BITS;
  localparam int EXT_W = (ACC_W > AW) ? ACC_W : AW;
  localparam int PRD_W = EXT_W + AW;
  // Raw coordinate bits kept after masking to the coordinate width
  localparam int XW    = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AW-1:0] smooth_alpha;
  logic [TW-1:0] timeout_ticks;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_alpha  <= tps_pkg::ALPHA_RESET;
      timeout_ticks <= tps_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (tps_pkg::reg_idx_t'(paddr[2]))
        tps_pkg::REG_ALPHA:   smooth_alpha  <= pwdata[AW-1:0];
        tps_pkg::REG_TIMEOUT: timeout_ticks <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tps_pkg::reg_idx_t'(paddr[2]))
      tps_pkg::REG_ALPHA:   prdata = {{(tps_pkg::DATA_W-AW){1'b0}}, smooth_alpha};
      tps_pkg::REG_TIMEOUT: prdata = timeout_ticks;
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the status register
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_valid;
  logic out_open;
  logic s1_fire;

  // Advance the input register when the status slot is empty or draining
  assign out_open     = !out_valid || status.ready;
  assign s1_fire      = s1_valid && out_open;
  assign events.ready = !s1_valid || out_open;
  assign status.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (events.ready) begin
        s1_valid <= events.valid;
      end
      if (out_open) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Captured event request
  logic [tps_pkg::FUNC_W-1:0] s1_func;
  logic [FW-1:0]              s1_x;
  logic [FW-1:0]              s1_y;
  logic [FW-1:0]              s1_seq;
  logic [TW-1:0]              s1_time;
  logic                       s1_ready_flag;

  always_ff @(posedge clk) begin
    if (events.ready && events.valid) begin
      s1_func       <= events.func;
      s1_x          <= events.x_coord;
      s1_y          <= events.y_coord;
      s1_seq        <= events.frame_seq;
      s1_time       <= events.time_stamp;
      s1_ready_flag <= events.ready_flag;
    end
  end

  // --------------------------------------------------------------------------
  // Tracker state
  // --------------------------------------------------------------------------
  logic             valid_bit,        valid_bit_next;
  logic             fresh_bit,        fresh_bit_next;
  logic [FW-1:0]    stored_seq,       stored_seq_next;
  logic [FW-1:0]    stored_raw_x,     stored_raw_x_next;
  logic [FW-1:0]    stored_raw_y,     stored_raw_y_next;
  logic [ACC_W-1:0] filter_x_acc,     filter_x_acc_next;
  logic [ACC_W-1:0] filter_y_acc,     filter_y_acc_next;
  logic [TW-1:0]    last_update_time, last_update_time_next;
  logic             fetch_ok_next;

  // Move acc toward target by alpha times the error, rounded half away
  // from zero on the magnitude
  function automatic logic [ACC_W-1:0] ema_step(
    input logic [ACC_W-1:0] acc,
    input logic [ACC_W-1:0] target,
    input logic [AW-1:0]    alpha
  );
    logic             up;
    logic [EXT_W-1:0] mag;
    logic [PRD_W-1:0] prod;
    logic [EXT_W:0]   step;
    logic [EXT_W-1:0] step_c;
    up   = target >= acc;
    mag  = up ? EXT_W'(target - acc) : EXT_W'(acc - target);
    prod = PRD_W'(mag) * PRD_W'(alpha) + PRD_W'(17'h08000);
    step = prod[PRD_W-1:16];
    step_c = (step > (EXT_W+1)'(mag)) ? mag : step[EXT_W-1:0];
    return up ? ACC_W'(acc + ACC_W'(step_c)) : ACC_W'(acc - ACC_W'(step_c));
  endfunction

  logic [AW-1:0]    alpha_eff;
  logic [XW-1:0]    x_m;
  logic [XW-1:0]    y_m;
  logic [ACC_W-1:0] x_target;
  logic [ACC_W-1:0] y_target;
  logic [TW-1:0]    age;

  assign alpha_eff = (smooth_alpha > tps_pkg::ALPHA_ONE) ? tps_pkg::ALPHA_ONE
                                                         : smooth_alpha;
  // Drop coordinate bits above the coordinate width
  assign x_m       = s1_x[XW-1:0];
  assign y_m       = s1_y[XW-1:0];
  assign x_target  = ACC_W'(ACC_W'(x_m) << FRAC_BITS);
  assign y_target  = ACC_W'(ACC_W'(y_m) << FRAC_BITS);
  assign age       = s1_time - last_update_time;

  always_comb begin
    valid_bit_next        = valid_bit;
    fresh_bit_next        = fresh_bit;
    stored_seq_next       = stored_seq;
    stored_raw_x_next     = stored_raw_x;
    stored_raw_y_next     = stored_raw_y;
    filter_x_acc_next     = filter_x_acc;
    filter_y_acc_next     = filter_y_acc;
    last_update_time_next = last_update_time;
    fetch_ok_next         = 1'b0;
    case (s1_func)
      tps_pkg::FUNC_FRAME: begin
        stored_raw_x_next     = FW'(x_m);
        stored_raw_y_next     = FW'(y_m);
        stored_seq_next       = s1_seq;
        last_update_time_next = s1_time;
        valid_bit_next        = 1'b1;
        fresh_bit_next        = 1'b1;
        // Load the filters directly on the first frame after both are zero
        if (filter_x_acc == '0 && filter_y_acc == '0) begin
          filter_x_acc_next = x_target;
          filter_y_acc_next = y_target;
        end else begin
          filter_x_acc_next = ema_step(filter_x_acc, x_target, alpha_eff);
          filter_y_acc_next = ema_step(filter_y_acc, y_target, alpha_eff);
        end
      end
      tps_pkg::FUNC_TICK: begin
        // Drop a target whose last frame is too old (wrapping time)
        if (valid_bit && age > timeout_ticks) begin
          valid_bit_next = 1'b0;
          fresh_bit_next = 1'b0;
        end
      end
      tps_pkg::FUNC_INJECT: begin
        stored_raw_x_next     = FW'(x_m);
        stored_raw_y_next     = FW'(y_m);
        filter_x_acc_next     = x_target;
        filter_y_acc_next     = y_target;
        valid_bit_next        = 1'b1;
        fresh_bit_next        = 1'b1;
        last_update_time_next = s1_time;
      end
      tps_pkg::FUNC_SET_READY: begin
        fresh_bit_next = s1_ready_flag;
        if (!s1_ready_flag) begin
          valid_bit_next = 1'b0;
        end
      end
      tps_pkg::FUNC_FETCH: begin
        if (valid_bit) begin
          fresh_bit_next = 1'b0;
          fetch_ok_next  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Commit state as the event moves into the status register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bit        <= 1'b0;
      fresh_bit        <= 1'b0;
      stored_seq       <= '0;
      stored_raw_x     <= '0;
      stored_raw_y     <= '0;
      filter_x_acc     <= '0;
      filter_y_acc     <= '0;
      last_update_time <= '0;
    end else if (s1_fire) begin
      valid_bit        <= valid_bit_next;
      fresh_bit        <= fresh_bit_next;
      stored_seq       <= stored_seq_next;
      stored_raw_x     <= stored_raw_x_next;
      stored_raw_y     <= stored_raw_y_next;
      filter_x_acc     <= filter_x_acc_next;
      filter_y_acc     <= filter_y_acc_next;
      last_update_time <= last_update_time_next;
    end
  end

  // --------------------------------------------------------------------------
  // Status register: hold while stalled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status.target_valid <= valid_bit_next;
      status.target_fresh <= fresh_bit_next;
      status.smooth_x     <= FW'(filter_x_acc_next[ACC_W-1:FRAC_BITS]);
      status.smooth_y     <= FW'(filter_y_acc_next[ACC_W-1:FRAC_BITS]);
      status.latest_x     <= stored_raw_x_next;
      status.latest_y     <= stored_raw_y_next;
      status.latest_seq   <= stored_seq_next;
      status.fetch_ok     <= fetch_ok_next;
    end
  end

endmodule
